>>> design/selective_repeat_receiver_window_defines.svh
// assertion macros shared by the receive window rtl
`ifndef SELECTIVE_REPEAT_RECEIVER_WINDOW_DEFINES_SVH
`define SELECTIVE_REPEAT_RECEIVER_WINDOW_DEFINES_SVH

// same-cycle implication
`define SRW_ASSERT_NOW(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("receive window assertion failed");

// next-cycle implication
`define SRW_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("receive window assertion failed");

`endif

>>> design/srw_pkg.sv
// types and constants of the selective repeat receive window
`timescale 1ns / 1ps

package srw_pkg;

    localparam int SEQ_IN_W        = 4;
    localparam int SEQ_COUNT_DEF   = 16;
    localparam int WINDOW_DEF      = 8;
    localparam int CHUNK_BYTES     = 3;
    localparam int FIELD_BYTES     = 3;
    localparam int LEN_CAP         = (CHUNK_BYTES < FIELD_BYTES) ? CHUNK_BYTES : FIELD_BYTES;

    typedef struct packed {
        logic [3:0] seq_index;
        logic [1:0] payload_len;
        logic [7:0] byte_zero;
        logic [7:0] byte_one;
        logic [7:0] byte_two;
    } frame_t;

    typedef struct packed {
        logic       is_ack;
        logic [3:0] ack_index;
        logic [1:0] chunk_len;
        logic [7:0] chunk_zero;
        logic [7:0] chunk_one;
        logic [7:0] chunk_two;
        logic       last;
    } result_t;

    // stored form of one slot
    typedef struct packed {
        logic [7:0] b_two;
        logic [7:0] b_one;
        logic [7:0] b_zero;
        logic [1:0] len;
    } chunk_t;

    typedef struct packed {
        logic in_window;
        logic is_expected;
    } prep_flags_t;

endpackage

>>> design/srw_frame_prep.sv
// frame decode: slot reduction, length clamp, window distance check
`timescale 1ns / 1ps

module srw_frame_prep #(
    parameter int SEQ_COUNT = srw_pkg::SEQ_COUNT_DEF,
    parameter int WINDOW    = srw_pkg::WINDOW_DEF,
    localparam int IDX_W    = $clog2(SEQ_COUNT)
) (
    input  srw_pkg::frame_t      frame,
    input  logic [IDX_W-1:0]     expected,
    output logic [IDX_W-1:0]     idx,
    output srw_pkg::chunk_t      chunk,
    output srw_pkg::prep_flags_t flags
);

    localparam int MW        = ((IDX_W > srw_pkg::SEQ_IN_W) ? IDX_W : srw_pkg::SEQ_IN_W) + 1;
    localparam int SEQ_MAX   = (1 << srw_pkg::SEQ_IN_W) - 1;
    localparam int MOD_STEPS = SEQ_MAX / SEQ_COUNT;
    localparam int DW        = (IDX_W + 1 > 8) ? IDX_W + 1 : 8;

    logic [MW-1:0]    red;
    logic [IDX_W:0]   diff;
    logic [IDX_W:0]   span;
    logic [DW-1:0]    dist_w;
    logic [1:0]       len;

    // index reduced by at most SEQ_MAX / SEQ_COUNT conditional subtracts
    always_comb
    begin
        red = MW'(frame.seq_index);
        for (int k = 0; k < MOD_STEPS; k++)
        begin
            if (red >= MW'(SEQ_COUNT))
            begin
                red = red - MW'(SEQ_COUNT);
            end
        end
        idx = red[IDX_W-1:0];
    end

    always_comb
    begin
        diff = {1'b0, idx} - {1'b0, expected};
        if (diff[IDX_W])
        begin
            span = diff + (IDX_W + 1)'(SEQ_COUNT);
        end
        else
        begin
            span = diff;
        end
        dist_w            = DW'(span);
        flags.in_window   = dist_w < DW'(WINDOW);
        flags.is_expected = (idx == expected);
    end

    always_comb
    begin
        if (frame.payload_len > 2'(srw_pkg::LEN_CAP))
        begin
            len = 2'(srw_pkg::LEN_CAP);
        end
        else
        begin
            len = frame.payload_len;
        end
        chunk.len    = len;
        chunk.b_zero = (len > 2'd0) ? frame.byte_zero : 8'h00;
        chunk.b_one  = (len > 2'd1) ? frame.byte_one  : 8'h00;
        chunk.b_two  = (len > 2'd2) ? frame.byte_two  : 8'h00;
    end

endmodule

>>> design/selective_repeat_receiver_window.sv
// after accept, S_WALK or S_ACK registers the first result once the output is free
// a new frame is stalled until the walk or the ack of the last frame is done
// delivery walk reads one slot a cycle unless stalled, via the single chunk memory read port
// the ack register parts the sides: the next frame is taken while an ack waits
// reset clears the expected slot, all used flags and the output; chunk memory is not cleared
`timescale 1ns / 1ps
`include "selective_repeat_receiver_window_defines.svh"

module selective_repeat_receiver_window #(
    parameter int SEQ_COUNT = srw_pkg::SEQ_COUNT_DEF,
    parameter int WINDOW    = srw_pkg::WINDOW_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             frame_valid,
    output logic             frame_stall,
    input  srw_pkg::frame_t  frame,
    output logic             result_valid,
    input  logic             result_stall,
    output srw_pkg::result_t result
);

    localparam int IDX_W = $clog2(SEQ_COUNT);
    localparam int CNT_W = $clog2(WINDOW + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_ACK
    } state_t;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     exp_reg, exp_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [SEQ_COUNT-1:0] full_reg, full_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_ack_reg, out_ack_next;
    logic [3:0]           ack_idx_reg, ack_idx_next;
    logic [3:0]           frame_idx_reg, frame_idx_next;

    srw_pkg::chunk_t      chunk_mem [SEQ_COUNT];
    srw_pkg::chunk_t      chunk_rd_reg;
    logic                 mem_we;
    logic                 mem_re;

    logic [IDX_W-1:0]     idx;
    srw_pkg::chunk_t      chunk_in;
    srw_pkg::prep_flags_t flags;
    logic                 in_accept;
    logic                 out_free;

    srw_frame_prep #(
        .SEQ_COUNT (SEQ_COUNT),
        .WINDOW    (WINDOW)
    ) u_prep (
        .frame    (frame),
        .expected (exp_reg),
        .idx      (idx),
        .chunk    (chunk_in),
        .flags    (flags)
    );

    assign frame_stall = (state_reg != S_IDLE);
    assign in_accept   = frame_valid && (state_reg == S_IDLE);
    assign out_free    = !out_valid_reg || !result_stall;

    always_comb
    begin
        state_next     = state_reg;
        exp_next       = exp_reg;
        cnt_next       = cnt_reg;
        full_next      = full_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_ack_next   = out_ack_reg;
        ack_idx_next   = ack_idx_reg;
        frame_idx_next = frame_idx_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    // kept apart from the ack register, which may still wait
                    frame_idx_next = frame.seq_index;
                    if (flags.in_window && !full_reg[idx])
                    begin
                        mem_we         = 1'b1;
                        full_next[idx] = 1'b1;
                    end
                    if (flags.in_window && flags.is_expected)
                    begin
                        state_next = S_WALK;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        state_next = S_ACK;
                    end
                end
            end
            S_WALK:
            begin
                if (out_free)
                begin
                    if (full_reg[exp_reg] && (cnt_reg < CNT_W'(WINDOW)))
                    begin
                        mem_re             = 1'b1;
                        full_next[exp_reg] = 1'b0;
                        exp_next           = (exp_reg == IDX_W'(SEQ_COUNT - 1)) ?
                                             '0 : exp_reg + IDX_W'(1);
                        cnt_next           = cnt_reg + CNT_W'(1);
                        out_valid_next     = 1'b1;
                        out_ack_next       = 1'b0;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_ack_next   = 1'b1;
                        ack_idx_next   = frame_idx_reg;
                        state_next     = S_IDLE;
                    end
                end
            end
            S_ACK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ack_next   = 1'b1;
                    ack_idx_next   = frame_idx_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            exp_reg       <= '0;
            cnt_reg       <= '0;
            full_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_ack_reg   <= 1'b0;
            ack_idx_reg   <= '0;
            frame_idx_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            exp_reg       <= exp_next;
            cnt_reg       <= cnt_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
            out_ack_reg   <= out_ack_next;
            ack_idx_reg   <= ack_idx_next;
            frame_idx_reg <= frame_idx_next;
        end
    end

    // chunk memory, registered read; the walk reads only after the write edge
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            chunk_mem[idx] <= chunk_in;
        end
        if (mem_re)
        begin
            chunk_rd_reg <= chunk_mem[exp_reg];
        end
    end

    assign result_valid      = out_valid_reg;
    assign result.is_ack     = out_ack_reg;
    assign result.ack_index  = out_ack_reg ? ack_idx_reg : 4'h0;
    assign result.chunk_len  = out_ack_reg ? 2'd0 : chunk_rd_reg.len;
    assign result.chunk_zero = out_ack_reg ? 8'h00 : chunk_rd_reg.b_zero;
    assign result.chunk_one  = out_ack_reg ? 8'h00 : chunk_rd_reg.b_one;
    assign result.chunk_two  = out_ack_reg ? 8'h00 : chunk_rd_reg.b_two;
    assign result.last       = out_ack_reg;

    // a pending result while idle can only be the ack of the previous frame
    `SRW_ASSERT_NOW(a_idle_holds_ack, clk, rst_n, (state_reg == S_IDLE) && out_valid_reg, out_ack_reg)
    `SRW_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, frame_valid && !frame_stall, frame_stall)
    `SRW_ASSERT_NEXT(a_exp_moves_in_walk, clk, rst_n, state_reg != S_WALK, exp_reg == $past(exp_reg))
    `SRW_ASSERT_NOW(a_walk_bounded, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(WINDOW))

endmodule
